/* design/sax_pkg.sv */
`timescale 1ns / 1ps

package sax_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAX_SEGMENT = 256;
    localparam int SUM_W       = SAMPLE_W + $clog2(MAX_SEGMENT);
    localparam int CNT_W       = $clog2(MAX_SEGMENT + 1);
    localparam int SYM_W       = 4;
    localparam int ALPHA_W     = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CNT_W;
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int BP_MAX      = 7;
    localparam int BP_IDX_W    = $clog2(BP_MAX);
    localparam int QUEUE_DEPTH = 2;
    localparam int ALPHA_MIN   = 3;
    localparam int ALPHA_MAX   = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SEGMENT_LENGTH = 1'b0;
    localparam t_cfg_idx CFG_ALPHABET_SIZE  = 1'b1;

    // closed segment handed from the accumulator to the divider
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic                    eos;
    } t_seg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef logic signed [SAMPLE_W-1:0] t_bp_row [BP_MAX];

    // Gaussian breakpoints scaled by 4096, unused tail entries are zero
    localparam t_bp_row BP3 = '{-16'sd1761, 16'sd1761, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    localparam t_bp_row BP4 = '{-16'sd2744, 16'sd0, 16'sd2744, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    localparam t_bp_row BP5 = '{-16'sd3441, -16'sd1024, 16'sd1024, 16'sd3441,
                                16'sd0, 16'sd0, 16'sd0};
    localparam t_bp_row BP6 = '{-16'sd3973, -16'sd1761, 16'sd0, 16'sd1761, 16'sd3973,
                                16'sd0, 16'sd0};
    localparam t_bp_row BP7 = '{-16'sd4383, -16'sd2335, -16'sd737, 16'sd737, 16'sd2335,
                                16'sd4383, 16'sd0};
    localparam t_bp_row BP8 = '{-16'sd4710, -16'sd2744, -16'sd1311, 16'sd0, 16'sd1311,
                                16'sd2744, 16'sd4710};

    function automatic logic signed [SAMPLE_W-1:0] breakpoint(
        input logic [ALPHA_W-1:0]  a,
        input logic [BP_IDX_W-1:0] idx
    );
        logic signed [SAMPLE_W-1:0] bp;
        unique case (a)
            4'd3:    bp = BP3[idx];
            4'd4:    bp = BP4[idx];
            4'd5:    bp = BP5[idx];
            4'd6:    bp = BP6[idx];
            4'd7:    bp = BP7[idx];
            default: bp = BP8[idx];
        endcase
        return bp;
    endfunction

endpackage

/* design/sax_sample_if.sv */
`timescale 1ns / 1ps

interface sax_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sax_pkg::SAMPLE_W-1:0]  sample;
    logic                                 end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

/* design/sax_result_if.sv */
`timescale 1ns / 1ps

interface sax_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sax_pkg::SAMPLE_W-1:0]  segment_mean;
    logic [sax_pkg::SYM_W-1:0]            symbol;
    logic [sax_pkg::CNT_W-1:0]            segment_count;
    logic                                 last_of_sequence;

    modport source (output valid, output segment_mean, output symbol,
                    output segment_count, output last_of_sequence, input ready);
    modport sink   (input valid, input segment_mean, input symbol,
                    input segment_count, input last_of_sequence, output ready);
endinterface

/* design/sax_front.sv */
`timescale 1ns / 1ps

module sax_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sax_pkg::CNT_W-1:0]   i_len,
    sax_sample_if.sink                  i_smp,
    input  logic                        i_full,
    output logic                        o_push,
    output sax_pkg::t_seg               o_seg
);

    logic signed [sax_pkg::SUM_W-1:0] r_sum, n_sum, w_sum;
    logic [sax_pkg::CNT_W-1:0]        r_cnt, n_cnt, w_cnt;
    logic                             w_acc, w_close;

    assign i_smp.ready = !i_full;
    assign w_acc       = i_smp.valid && i_smp.ready;
    assign w_sum       = r_sum + sax_pkg::SUM_W'(i_smp.sample);
    assign w_cnt       = r_cnt + sax_pkg::CNT_W'(1);
    // a lowered length closes the segment at the next sample
    assign w_close     = i_smp.end_of_sequence || (w_cnt >= i_len);

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (w_acc) begin
            if (w_close) begin
                n_sum = '0;
                n_cnt = '0;
            end else begin
                n_sum = w_sum;
                n_cnt = w_cnt;
            end
        end
    end

    assign o_push      = w_acc && w_close;
    assign o_seg.sum   = w_sum;
    assign o_seg.count = w_cnt;
    assign o_seg.eos   = i_smp.end_of_sequence;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* design/sax_queue.sv */
`timescale 1ns / 1ps

module sax_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sax_pkg::t_seg i_seg,
    input  logic          i_pop,
    output sax_pkg::t_seg o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int PTR_W  = $clog2(sax_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(sax_pkg::QUEUE_DEPTH + 1);

    sax_pkg::t_seg     r_mem [sax_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [FILL_W-1:0] r_fill;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == FILL_W'(sax_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(sax_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(sax_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

/* design/sax_back.sv */
`timescale 1ns / 1ps

module sax_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sax_pkg::ALPHA_W-1:0]   i_alpha,
    input  sax_pkg::t_seg                 i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    sax_result_if.source                  o_res
);

    sax_pkg::t_back_state r_state, n_state;

    logic [sax_pkg::CNT_W-1:0]          r_rem, r_div;
    logic [sax_pkg::SUM_W-1:0]          r_quo;
    logic [sax_pkg::STEP_W-1:0]         r_step;
    logic                               r_neg, r_eos;

    logic                               r_out_valid;
    logic signed [sax_pkg::SAMPLE_W-1:0] r_mean;
    logic [sax_pkg::SYM_W-1:0]          r_sym;
    logic [sax_pkg::CNT_W-1:0]          r_count;
    logic                               r_last;

    logic                               w_load;
    logic                               w_last_step;
    logic [sax_pkg::CNT_W:0]            w_part;
    logic                               w_ge;
    logic [sax_pkg::SUM_W-1:0]          w_mag, w_signed_quo;
    logic signed [sax_pkg::SAMPLE_W-1:0] w_mean;
    logic [sax_pkg::SYM_W-1:0]          w_sym;
    logic                               w_found;

    assign w_last_step = (r_step == sax_pkg::STEP_W'(sax_pkg::SUM_W - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sax_pkg::BK_IDLE: if (!i_empty) n_state = sax_pkg::BK_DIV;
            sax_pkg::BK_DIV:  if (w_last_step) n_state = sax_pkg::BK_DONE;
            sax_pkg::BK_DONE: if (!r_out_valid || o_res.ready) n_state = sax_pkg::BK_IDLE;
            default:          n_state = sax_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            sax_pkg::BK_IDLE: o_pop  = !i_empty;
            sax_pkg::BK_DONE: w_load = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    // restoring divide on the magnitude, one quotient bit per cycle
    assign w_mag  = i_head.sum[sax_pkg::SUM_W-1] ? -i_head.sum : i_head.sum;
    assign w_part = {r_rem, r_quo[sax_pkg::SUM_W-1]};
    assign w_ge   = (w_part >= {1'b0, r_div});

    assign w_signed_quo = r_neg ? -r_quo : r_quo;
    assign w_mean       = w_signed_quo[sax_pkg::SAMPLE_W-1:0];

    // first breakpoint at or above the mean; the top interval otherwise
    always_comb begin
        w_sym   = i_alpha;
        w_found = 1'b0;
        for (int i = 0; i < sax_pkg::BP_MAX; i++) begin
            if (!w_found && (i < int'(i_alpha) - 1) &&
                (w_mean <= sax_pkg::breakpoint(i_alpha, sax_pkg::BP_IDX_W'(i)))) begin
                w_sym   = sax_pkg::SYM_W'(i + 1);
                w_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg  <= i_head.sum[sax_pkg::SUM_W-1];
            r_quo  <= w_mag;
            r_rem  <= '0;
            r_div  <= i_head.count;
            r_eos  <= i_head.eos;
            r_step <= '0;
        end else if (r_state == sax_pkg::BK_DIV) begin
            r_rem  <= w_ge ? sax_pkg::CNT_W'(w_part - {1'b0, r_div})
                           : w_part[sax_pkg::CNT_W-1:0];
            r_quo  <= {r_quo[sax_pkg::SUM_W-2:0], w_ge};
            r_step <= r_step + sax_pkg::STEP_W'(1);
        end
        if (w_load) begin
            r_mean  <= w_mean;
            r_sym   <= w_sym;
            r_count <= r_div;
            r_last  <= r_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sax_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.segment_mean     = r_mean;
    assign o_res.symbol           = r_sym;
    assign o_res.segment_count    = r_count;
    assign o_res.last_of_sequence = r_last;

endmodule

/* design/sax_symbolizer_top.sv */
`timescale 1ns / 1ps

// channel   dir  transaction                                     handshake
// i_smp     in   sample (Q3.12), end_of_sequence                 valid/ready
// o_res     out  segment_mean, symbol, segment_count, last flag  valid/ready
// i_cfg_*   in   register write: index, data                     write enable
//
// Samples are taken one per cycle while the segment queue has room.
// Each closed segment goes through dispatch, a 24-step divider and load in
// the back end, one segment at a time, so short segments limit the rate.
// Synchronous active-low reset clears accumulator, queue and output valid.
// The output register lets the divider start the next segment while a result
// waits; the queue lets the front keep summing while the divider is busy.

module sax_symbolizer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sax_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sax_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sax_sample_if.sink                       i_smp,
    sax_result_if.source                     o_res
);

    logic [sax_pkg::CNT_W-1:0]   r_seg_len;
    logic [sax_pkg::ALPHA_W-1:0] r_alpha;
    logic [sax_pkg::CNT_W-1:0]   w_len;
    logic [sax_pkg::ALPHA_W-1:0] w_alpha;

    logic          w_push, w_pop, w_empty, w_full;
    sax_pkg::t_seg w_seg_in, w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= sax_pkg::CNT_W'(8);
            r_alpha   <= sax_pkg::ALPHA_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sax_pkg::CFG_SEGMENT_LENGTH: r_seg_len <= i_cfg_data[sax_pkg::CNT_W-1:0];
                sax_pkg::CFG_ALPHABET_SIZE:  r_alpha   <= i_cfg_data[sax_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length acts as one, lengths and alphabet sizes saturate
    always_comb begin
        if (r_seg_len == '0) begin
            w_len = sax_pkg::CNT_W'(1);
        end else if (r_seg_len > sax_pkg::CNT_W'(sax_pkg::MAX_SEGMENT)) begin
            w_len = sax_pkg::CNT_W'(sax_pkg::MAX_SEGMENT);
        end else begin
            w_len = r_seg_len;
        end
        if (r_alpha < sax_pkg::ALPHA_W'(sax_pkg::ALPHA_MIN)) begin
            w_alpha = sax_pkg::ALPHA_W'(sax_pkg::ALPHA_MIN);
        end else if (r_alpha > sax_pkg::ALPHA_W'(sax_pkg::ALPHA_MAX)) begin
            w_alpha = sax_pkg::ALPHA_W'(sax_pkg::ALPHA_MAX);
        end else begin
            w_alpha = r_alpha;
        end
    end

    sax_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_len   (w_len),
        .i_smp   (i_smp),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_seg   (w_seg_in)
    );

    sax_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_seg   (w_seg_in),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sax_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_alpha (w_alpha),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
